// ===== rtl/jesc_pkg.sv =====
// ----------------------------------------------------------------------------
// jesc_pkg
// Shared types, character codes and helpers for the JSON string unescaper.
// ----------------------------------------------------------------------------
package jesc_pkg;

	// decode phase, one-hot
	typedef enum logic [5:0] {
		PH_NORMAL = 6'b000001,
		PH_ESCAPE = 6'b000010,
		PH_HEX1   = 6'b000100,
		PH_SKIP1  = 6'b001000,
		PH_SKIP2  = 6'b010000,
		PH_HEX2   = 6'b100000
	} jesc_phase_t;

	// results of one input item, first byte in bytes[0]
	typedef struct packed {
		logic [2:0]      cnt;
		logic            bad;
		logic [3:0][7:0] bytes;
	} jesc_res_t;

	localparam logic [7:0] CH_QUOTE  = 8'h22;
	localparam logic [7:0] CH_SLASH  = 8'h2F;
	localparam logic [7:0] CH_BSLASH = 8'h5C;
	localparam logic [7:0] CH_B      = 8'h62;
	localparam logic [7:0] CH_F      = 8'h66;
	localparam logic [7:0] CH_N      = 8'h6E;
	localparam logic [7:0] CH_R      = 8'h72;
	localparam logic [7:0] CH_T      = 8'h74;
	localparam logic [7:0] CH_U      = 8'h75;

	localparam logic [7:0] CTL_BS = 8'h08;
	localparam logic [7:0] CTL_FF = 8'h0C;
	localparam logic [7:0] CTL_LF = 8'h0A;
	localparam logic [7:0] CTL_CR = 8'h0D;
	localparam logic [7:0] CTL_HT = 8'h09;

	localparam logic [15:0] SURR_HI_MIN = 16'hD800;
	localparam logic [15:0] SURR_HI_MAX = 16'hDBFF;
	localparam logic [20:0] SUPP_BASE   = 21'h10000;

	localparam logic [20:0] CP_MAX1 = 21'h00007F;
	localparam logic [20:0] CP_MAX2 = 21'h0007FF;
	localparam logic [20:0] CP_MAX3 = 21'h00FFFF;

	localparam logic [7:0] LEAD2 = 8'hC0;
	localparam logic [7:0] LEAD3 = 8'hE0;
	localparam logic [7:0] LEAD4 = 8'hF0;
	localparam logic [7:0] CONT  = 8'h80;

	// {valid, value}
	function automatic logic [4:0] hex_digit(input logic [7:0] c);
		logic [4:0] r;
		r = 5'b0;
		if (c inside {[8'h30:8'h39]}) begin
			r = {1'b1, 4'(c - 8'h30)};
		end else if (c inside {[8'h61:8'h66]}) begin
			r = {1'b1, 4'(c - 8'h57)};
		end else if (c inside {[8'h41:8'h46]}) begin
			r = {1'b1, 4'(c - 8'h37)};
		end
		return r;
	endfunction

endpackage

// ===== rtl/jesc_utf8_enc.sv =====
// ----------------------------------------------------------------------------
// jesc_utf8_enc
// Encodes one code point (up to 0x10FFFF) as 1 to 4 UTF-8 bytes.
// ----------------------------------------------------------------------------
module jesc_utf8_enc (
	input  logic [20:0]      cp,
	output logic [2:0]       cnt,
	output logic [3:0][7:0]  bytes
);
	import jesc_pkg::*;

	always_comb begin
		bytes = '0;
		if (cp <= CP_MAX1) begin
			cnt      = 3'd1;
			bytes[0] = cp[7:0];
		end else if (cp <= CP_MAX2) begin
			cnt      = 3'd2;
			bytes[0] = LEAD2 | {3'b0, cp[10:6]};
			bytes[1] = CONT  | {2'b0, cp[5:0]};
		end else if (cp <= CP_MAX3) begin
			cnt      = 3'd3;
			bytes[0] = LEAD3 | {4'b0, cp[15:12]};
			bytes[1] = CONT  | {2'b0, cp[11:6]};
			bytes[2] = CONT  | {2'b0, cp[5:0]};
		end else begin
			cnt      = 3'd4;
			bytes[0] = LEAD4 | {5'b0, cp[20:18]};
			bytes[1] = CONT  | {2'b0, cp[17:12]};
			bytes[2] = CONT  | {2'b0, cp[11:6]};
			bytes[3] = CONT  | {2'b0, cp[5:0]};
		end
	end

endmodule

// ===== rtl/jesc_decode.sv =====
// ----------------------------------------------------------------------------
// jesc_decode
// Escape state machine: holds phase, hex digits and pending high surrogate,
// and forms the result bytes of one input byte.
// ----------------------------------------------------------------------------
module jesc_decode (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                step,
	input  logic [7:0]          c,
	output jesc_pkg::jesc_res_t res
);
	import jesc_pkg::*;

	jesc_phase_t phase_q, phase_d;
	logic [1:0]  dcnt_q, dcnt_d;
	logic [15:0] acc_q, acc_d;
	logic [9:0]  high_q, high_d;

	logic [4:0]      hd;
	logic [15:0]     acc_new;
	logic [20:0]     cp;
	logic [2:0]      enc_cnt;
	logic [3:0][7:0] enc_bytes;

	assign hd      = hex_digit(c);
	assign acc_new = {acc_q[11:0], hd[3:0]};
	// first group alone, or combined surrogate pair
	assign cp = (phase_q == PH_HEX1) ? {5'b0, acc_new}
		: SUPP_BASE + {1'b0, high_q, 10'b0} + {11'b0, acc_new[9:0]};

	jesc_utf8_enc u_enc (
		.cp    (cp),
		.cnt   (enc_cnt),
		.bytes (enc_bytes)
	);

	always_comb begin
		phase_d = phase_q;
		dcnt_d  = dcnt_q;
		acc_d   = acc_q;
		high_d  = high_q;
		res     = '0;
		case (phase_q)
			PH_ESCAPE: begin
				phase_d = PH_NORMAL;
				res.cnt = 3'd1;
				case (c)
					CH_QUOTE, CH_SLASH, CH_BSLASH: res.bytes[0] = c;
					CH_B: res.bytes[0] = CTL_BS;
					CH_F: res.bytes[0] = CTL_FF;
					CH_N: res.bytes[0] = CTL_LF;
					CH_R: res.bytes[0] = CTL_CR;
					CH_T: res.bytes[0] = CTL_HT;
					CH_U: begin
						res.cnt = 3'd0;
						phase_d = PH_HEX1;
						dcnt_d  = 2'd0;
						acc_d   = 16'd0;
					end
					default: res.cnt = 3'd0; // unknown letter dropped
				endcase
			end
			PH_HEX1, PH_HEX2: begin
				if (!hd[4]) begin
					res.cnt = 3'd1;
					res.bad = 1'b1;
					phase_d = PH_NORMAL;
					dcnt_d  = 2'd0;
				end else begin
					acc_d = acc_new;
					if (dcnt_q != 2'd3) begin
						dcnt_d = dcnt_q + 2'd1;
					end else begin
						dcnt_d = 2'd0;
						if (phase_q == PH_HEX1 && acc_new >= SURR_HI_MIN
								&& acc_new <= SURR_HI_MAX) begin
							high_d  = acc_new[9:0];
							phase_d = PH_SKIP1;
						end else begin
							phase_d   = PH_NORMAL;
							res.cnt   = enc_cnt;
							res.bytes = enc_bytes;
						end
					end
				end
			end
			PH_SKIP1: phase_d = PH_SKIP2;
			PH_SKIP2: begin
				phase_d = PH_HEX2;
				dcnt_d  = 2'd0;
				acc_d   = 16'd0;
			end
			default: begin
				phase_d = PH_NORMAL;
				if (c == CH_BSLASH) begin
					phase_d = PH_ESCAPE;
				end else begin
					res.cnt      = 3'd1;
					res.bytes[0] = c;
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_NORMAL;
			dcnt_q  <= 2'd0;
			acc_q   <= 16'd0;
			high_q  <= 10'd0;
		end else if (step) begin
			phase_q <= phase_d;
			dcnt_q  <= dcnt_d;
			acc_q   <= acc_d;
			high_q  <= high_d;
		end
	end

endmodule

// ===== rtl/jesc_obuf.sv =====
// ----------------------------------------------------------------------------
// jesc_obuf
// Result register: holds the bytes of one input item and sends them one per
// cycle while m_tready is high; reloads when empty or as the last byte leaves.
// ----------------------------------------------------------------------------
module jesc_obuf (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                load,
	input  jesc_pkg::jesc_res_t res,
	output logic                can_load,
	output logic                m_tvalid,
	input  logic                m_tready,
	output logic [7:0]          m_tdata,
	output logic                m_tlast,
	output logic                m_tuser
);
	import jesc_pkg::*;

	logic [2:0]      cnt_q;
	logic            bad_q;
	logic [3:0][7:0] bytes_q;

	assign m_tvalid = (cnt_q != 3'd0);
	assign m_tdata  = bytes_q[0];
	assign m_tlast  = (cnt_q == 3'd1);
	assign m_tuser  = bad_q;
	assign can_load = (cnt_q == 3'd0) || (cnt_q == 3'd1 && m_tready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 3'd0;
		end else if (load) begin
			cnt_q <= res.cnt;
		end else if (m_tvalid && m_tready) begin
			cnt_q <= cnt_q - 3'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			bytes_q <= res.bytes;
			bad_q   <= res.bad;
		end else if (m_tvalid && m_tready) begin
			bytes_q <= {8'h00, bytes_q[3:1]};
		end
	end

endmodule

// ===== rtl/json_escape_to_utf8_decoder.sv =====
// ----------------------------------------------------------------------------
// json_escape_to_utf8_decoder
// Unescapes JSON string content bytes and emits the decoded UTF-8 stream.
// ----------------------------------------------------------------------------
//  channel | dir | tdata            | tlast       | tuser
//  s_*     | in  | [7:0] in_byte    | -           | -
//  m_*     | out | [7:0] out_byte   | last_of_run | bad_escape
//
// One input item per cycle is taken while every item yields at most one
// result byte and m_tready stays high. An item that yields more (a finished
// \u escape, 2 to 4 bytes) holds the result register until its last byte
// is taken. An accepted byte waits in the input register and is then decoded
// into the result register, whose first byte shows on m_*. Reset clears the
// escape state and both valid flags; no clearing pass is needed. A stall on
// m_tready backs up through the result register into s_tready.
// ----------------------------------------------------------------------------
module json_escape_to_utf8_decoder (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_tvalid,
	output logic       s_tready,
	input  logic [7:0] s_tdata,   // [7:0] in_byte
	output logic       m_tvalid,
	input  logic       m_tready,
	output logic [7:0] m_tdata,   // [7:0] out_byte
	output logic       m_tlast,   // last_of_run
	output logic       m_tuser    // bad_escape
);
	import jesc_pkg::*;

	// input register
	logic       v_s1;
	logic [7:0] byte_s1;

	logic      can_load;
	logic      load;
	jesc_res_t res;

	// decode the held byte once the result register can take its bytes
	assign load     = v_s1 && can_load;
	assign s_tready = !v_s1 || can_load;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (s_tvalid && s_tready) begin
			v_s1 <= 1'b1;
		end else if (load) begin
			v_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			byte_s1 <= s_tdata;
		end
	end

	jesc_decode u_dec (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (load),
		.c      (byte_s1),
		.res    (res)
	);

	jesc_obuf u_obuf (
		.clk      (clk),
		.arst_n   (arst_n),
		.load     (load),
		.res      (res),
		.can_load (can_load),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast),
		.m_tuser  (m_tuser)
	);

endmodule

// ===== verif/tb_json_escape_to_utf8_decoder.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_json_escape_to_utf8_decoder
// Self-checking bench for the JSON string unescaper. A directed table of
// string content comes first, then about 420 random items. The random items
// are mostly well-formed escapes, unicode escapes and surrogate pairs, with
// plain bytes, bad hex digits and noise mixed in. Each accepted item runs
// through a local decoder model. Every output byte is checked against the
// oldest pending prediction. The sender bursts and the receiver stalls at
// random, and the receiver holds off once for a long stretch.
// ----------------------------------------------------------------------------
module tb_json_escape_to_utf8_decoder;
	import jesc_pkg::*;

	localparam int N_RANDOM   = 420;
	localparam int IDLE_LIMIT = 1000;  // cycles with no item moving on either side
	localparam int HOLD_AT    = 150;   // input items accepted before the long hold-off
	localparam int HOLD_LEN   = 80;
	localparam int N_DIRECTED = 28;

	// one output item as the block should produce it
	typedef struct packed {
		logic [7:0] data;
		logic       last;
		logic       bad;
	} decoded_t;

	// one stimulus byte; rows marked fixed carry a single hand-written result
	typedef struct packed {
		logic [7:0] data;
		logic       fixed;
		logic [7:0] want;
		logic       bad;
	} stim_t;

	// receiver stall behaviour, changed at the end of each random span
	typedef enum logic [1:0] {
		RX_FLOW,    // always ready
		RX_RANDOM,  // drops ready about a third of the time
		RX_COMB     // drops ready a quarter of the time, in a regular comb
	} rx_mode_t;

	logic       clk      = 1'b0;
	logic       arst_n   = 1'b0;
	logic       s_tvalid = 1'b0;
	logic [7:0] s_tdata  = 8'h00;
	logic       m_tready = 1'b0;
	logic       s_tready;
	logic       m_tvalid;
	logic [7:0] m_tdata;
	logic       m_tlast;
	logic       m_tuser;

	json_escape_to_utf8_decoder u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast),
		.m_tuser  (m_tuser)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
	end

	// ------------------------------------------------------------------------
	// Directed table. Fixed rows are the ones whose answer is obvious: plain
	// bytes at both ends of the range, a control escape, and a bad hex digit.
	// The rest is left to the model: an unknown escape letter (dropped), a
	// lone low surrogate (three bytes as is), and the top high surrogate with
	// two arbitrary skipped bytes and a second group that is not a low
	// surrogate (only its low ten bits count).
	// ------------------------------------------------------------------------
	stim_t directed_rows [0:N_DIRECTED-1] = '{
		'{8'h00,     1'b1, 8'h00,  1'b0},
		'{8'hFF,     1'b1, 8'hFF,  1'b0},
		'{CH_BSLASH, 1'b0, 8'h00,  1'b0},
		'{CH_N,      1'b1, CTL_LF, 1'b0},
		'{CH_BSLASH, 1'b0, 8'h00,  1'b0},
		'{"q",       1'b0, 8'h00,  1'b0},  // unknown letter, nothing out
		'{CH_BSLASH, 1'b0, 8'h00,  1'b0},
		'{CH_U,      1'b0, 8'h00,  1'b0},
		'{"0",       1'b0, 8'h00,  1'b0},
		'{"G",       1'b1, 8'h00,  1'b1},  // not hex: error item
		'{CH_BSLASH, 1'b0, 8'h00,  1'b0},
		'{CH_U,      1'b0, 8'h00,  1'b0},
		'{"D",       1'b0, 8'h00,  1'b0},
		'{"C",       1'b0, 8'h00,  1'b0},
		'{"0",       1'b0, 8'h00,  1'b0},
		'{"0",       1'b0, 8'h00,  1'b0},  // lone low surrogate DC00
		'{CH_BSLASH, 1'b0, 8'h00,  1'b0},
		'{CH_U,      1'b0, 8'h00,  1'b0},
		'{"D",       1'b0, 8'h00,  1'b0},
		'{"B",       1'b0, 8'h00,  1'b0},
		'{"F",       1'b0, 8'h00,  1'b0},
		'{"f",       1'b0, 8'h00,  1'b0},  // high surrogate DBFF
		'{8'h00,     1'b0, 8'h00,  1'b0},  // skipped
		'{8'hFF,     1'b0, 8'h00,  1'b0},  // skipped
		'{"0",       1'b0, 8'h00,  1'b0},
		'{"0",       1'b0, 8'h00,  1'b0},
		'{"0",       1'b0, 8'h00,  1'b0},
		'{"0",       1'b0, 8'h00,  1'b0}   // 10FC00, four bytes
	};

	stim_t    stim_q [$];
	decoded_t pending_bytes [$];
	int       n_accepted = 0;
	int       n_err      = 0;

	// ------------------------------------------------------------------------
	// Decoder model state
	// ------------------------------------------------------------------------
	jesc_phase_t esc_phase = PH_NORMAL;
	logic [1:0]  n_digits  = 2'd0;
	logic [15:0] hex_acc   = 16'h0000;
	logic [9:0]  hi_bits   = 10'h000;

	function automatic bit hex_val(input logic [7:0] c, output logic [3:0] v);
		v = 4'h0;
		if (c >= "0" && c <= "9") begin
			v = 4'(c - "0");
			return 1'b1;
		end
		if (c >= "a" && c <= "f") begin
			v = 4'(c - "a" + 8'd10);
			return 1'b1;
		end
		if (c >= "A" && c <= "F") begin
			v = 4'(c - "A" + 8'd10);
			return 1'b1;
		end
		return 1'b0;
	endfunction

	function automatic int utf8_encode(input logic [20:0] cp, output decoded_t [3:0] r);
		r = '0;
		if (cp <= CP_MAX1) begin
			r[0].data = cp[7:0];
			return 1;
		end
		if (cp <= CP_MAX2) begin
			r[0].data = LEAD2 | {3'b0, cp[10:6]};
			r[1].data = CONT  | {2'b0, cp[5:0]};
			return 2;
		end
		if (cp <= CP_MAX3) begin
			r[0].data = LEAD3 | {4'b0, cp[15:12]};
			r[1].data = CONT  | {2'b0, cp[11:6]};
			r[2].data = CONT  | {2'b0, cp[5:0]};
			return 3;
		end
		r[0].data = LEAD4 | {5'b0, cp[20:18]};
		r[1].data = CONT  | {2'b0, cp[17:12]};
		r[2].data = CONT  | {2'b0, cp[11:6]};
		r[3].data = CONT  | {2'b0, cp[5:0]};
		return 4;
	endfunction

	// advances the model by one input byte; returns how many bytes come out
	function automatic int unescape_step(input logic [7:0] c, output decoded_t [3:0] r);
		int          n;
		logic [3:0]  v;
		logic [20:0] cp;
		n = 0;
		r = '0;
		case (esc_phase)
			PH_ESCAPE: begin
				esc_phase = PH_NORMAL;
				case (c)
					CH_QUOTE, CH_SLASH, CH_BSLASH: begin r[0].data = c;      n = 1; end
					CH_B:                          begin r[0].data = CTL_BS; n = 1; end
					CH_F:                          begin r[0].data = CTL_FF; n = 1; end
					CH_N:                          begin r[0].data = CTL_LF; n = 1; end
					CH_R:                          begin r[0].data = CTL_CR; n = 1; end
					CH_T:                          begin r[0].data = CTL_HT; n = 1; end
					CH_U: begin
						esc_phase = PH_HEX1;
						n_digits  = 2'd0;
						hex_acc   = 16'h0000;
					end
					default: ;
				endcase
			end
			PH_HEX1, PH_HEX2: begin
				if (!hex_val(c, v)) begin
					r[0].bad  = 1'b1;
					n         = 1;
					esc_phase = PH_NORMAL;
					n_digits  = 2'd0;
				end else begin
					hex_acc = {hex_acc[11:0], v};
					if (n_digits != 2'd3) begin
						n_digits = n_digits + 2'd1;
					end else begin
						n_digits = 2'd0;
						if (esc_phase == PH_HEX1 && hex_acc >= SURR_HI_MIN
								&& hex_acc <= SURR_HI_MAX) begin
							hi_bits   = hex_acc[9:0];
							esc_phase = PH_SKIP1;
						end else begin
							// first group as is; second group: low ten bits only, whatever it holds
							cp = (esc_phase == PH_HEX1) ? {5'b0, hex_acc}
								: SUPP_BASE + {1'b0, hi_bits, hex_acc[9:0]};
							esc_phase = PH_NORMAL;
							n = utf8_encode(cp, r);
						end
					end
				end
			end
			PH_SKIP1: esc_phase = PH_SKIP2;
			PH_SKIP2: begin
				esc_phase = PH_HEX2;
				n_digits  = 2'd0;
				hex_acc   = 16'h0000;
			end
			default: begin
				esc_phase = PH_NORMAL;
				if (c == CH_BSLASH) begin
					esc_phase = PH_ESCAPE;
				end else begin
					r[0].data = c;
					n = 1;
				end
			end
		endcase
		if (n > 0) begin
			r[n-1].last = 1'b1;
		end
		return n;
	endfunction

	// ------------------------------------------------------------------------
	// Random stimulus helpers
	// ------------------------------------------------------------------------
	task automatic push_byte(input logic [7:0] b);
		stim_q.insert(stim_q.size(), stim_t'{b, 1'b0, 8'h00, 1'b0});
	endtask

	// four hex digits of v, mixed case; a non-hex byte replaces digit bad_at
	// and ends the group there (ok comes back low)
	task automatic push_hex(input logic [15:0] v, input int bad_at, output bit ok);
		logic [3:0] nib;
		logic [3:0] dummy;
		logic [7:0] b;
		ok = 1'b1;
		for (int i = 0; i < 4; i++) begin
			nib = v[15-4*i -: 4];
			if (i == bad_at) begin
				do b = 8'($urandom_range(0, 255)); while (hex_val(b, dummy));
				push_byte(b);
				ok = 1'b0;
				return;
			end
			if (nib < 4'd10) begin
				b = "0" + {4'b0, nib};
			end else begin
				b = ($urandom_range(0, 1) ? "a" : "A") + {4'b0, nib} - 8'd10;
			end
			push_byte(b);
		end
	endtask

	task automatic build_random;
		logic [7:0]  simple_esc [8];
		logic [15:0] cp;
		bit          ok;
		int          pick;
		simple_esc = '{CH_QUOTE, CH_SLASH, CH_BSLASH, CH_B, CH_F, CH_N, CH_R, CH_T};
		while (stim_q.size() < N_DIRECTED + N_RANDOM) begin
			pick = $urandom_range(0, 99);
			if (pick < 25) begin
				// plain byte, any value but the escape opener
				cp[7:0] = 8'($urandom_range(0, 255));
				push_byte(cp[7:0] == CH_BSLASH ? 8'h5B : cp[7:0]);
			end else if (pick < 45) begin
				push_byte(CH_BSLASH);
				push_byte(simple_esc[$urandom_range(0, 7)]);
			end else if (pick < 50) begin
				// escape with an arbitrary letter, mostly unknown ones
				push_byte(CH_BSLASH);
				push_byte(8'($urandom_range(0, 255)));
			end else if (pick < 75) begin
				case ($urandom_range(0, 3))
					0: cp = 16'($urandom_range(0, 16'h007F));
					1: cp = 16'($urandom_range(16'h0080, 16'h07FF));
					2: begin
						cp = 16'($urandom_range(16'h0800, 16'hFFFF));
						if (cp >= SURR_HI_MIN && cp <= SURR_HI_MAX) begin
							cp = cp ^ 16'h2000;
						end
					end
					default: cp = 16'($urandom_range(16'hDC00, 16'hDFFF));
				endcase
				push_byte(CH_BSLASH);
				push_byte(CH_U);
				push_hex(cp, ($urandom_range(0, 9) == 0) ? $urandom_range(0, 3) : -1, ok);
			end else if (pick < 93) begin
				// surrogate pair; skipped bytes are the backslash-u half the time
				push_byte(CH_BSLASH);
				push_byte(CH_U);
				push_hex(SURR_HI_MIN | 16'($urandom_range(0, 1023)),
					($urandom_range(0, 14) == 0) ? $urandom_range(0, 3) : -1, ok);
				if (ok) begin
					if ($urandom_range(0, 1)) begin
						push_byte(CH_BSLASH);
						push_byte(CH_U);
					end else begin
						push_byte(8'($urandom_range(0, 255)));
						push_byte(8'($urandom_range(0, 255)));
					end
					cp = ($urandom_range(0, 4) == 0) ? 16'($urandom_range(0, 16'hFFFF))
						: (16'hDC00 | 16'($urandom_range(0, 1023)));
					push_hex(cp, ($urandom_range(0, 9) == 0) ? $urandom_range(0, 3) : -1, ok);
				end
			end else begin
				// noise, backslash included
				push_byte(8'($urandom_range(0, 255)));
			end
		end
	endtask

	// ------------------------------------------------------------------------
	// Input side: every accepted item goes through the model
	// ------------------------------------------------------------------------
	always @(posedge clk) begin : in_mon
		decoded_t [3:0] res;
		int             n;
		if (arst_n && s_tvalid && s_tready) begin
			n = unescape_step(s_tdata, res);
			if (stim_q[n_accepted].fixed) begin
				// the model still runs to keep its state in step
				pending_bytes.insert(pending_bytes.size(), decoded_t'{
					stim_q[n_accepted].want, 1'b1, stim_q[n_accepted].bad});
			end else begin
				for (int i = 0; i < n; i++) begin
					pending_bytes.insert(pending_bytes.size(), res[i]);
				end
			end
			n_accepted++;
		end
	end

	// ------------------------------------------------------------------------
	// Output side: compare each item with the oldest prediction
	// ------------------------------------------------------------------------
	always @(posedge clk) begin : out_mon
		decoded_t exp_b;
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_bytes.size() == 0) begin
				$error("unexpected output item: out_byte %02h last %0b bad %0b",
					m_tdata, m_tlast, m_tuser);
				n_err++;
			end else begin
				exp_b = pending_bytes.pop_front();
				if (m_tdata !== exp_b.data) begin
					$error("out_byte: expected %02h, got %02h", exp_b.data, m_tdata);
					n_err++;
				end
				if (m_tlast !== exp_b.last) begin
					$error("last_of_run: expected %0b, got %0b", exp_b.last, m_tlast);
					n_err++;
				end
				if (m_tuser !== exp_b.bad) begin
					$error("bad_escape: expected %0b, got %0b", exp_b.bad, m_tuser);
					n_err++;
				end
			end
		end
	end

	// ------------------------------------------------------------------------
	// Receiver: changes stall mode after each random span; once HOLD_AT items
	// are in, it holds off long enough to back up into s_tready.
	// ------------------------------------------------------------------------
	initial begin : rx
		rx_mode_t mode;
		int       span;
		int       hold;
		bit       held;
		mode = RX_FLOW;
		span = 0;
		hold = 0;
		held = 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (!held && n_accepted >= HOLD_AT) begin
				held = 1'b1;
				hold = HOLD_LEN;
			end
			if (span == 0) begin
				mode = rx_mode_t'($urandom_range(0, 2));
				span = $urandom_range(20, 80);
			end
			span--;
			if (hold > 0) begin
				hold--;
				m_tready <= 1'b0;
			end else begin
				case (mode)
					RX_FLOW:   m_tready <= 1'b1;
					RX_RANDOM: m_tready <= ($urandom_range(0, 2) != 0);
					default:   m_tready <= (span % 4 != 0);
				endcase
			end
		end
	end

	// ------------------------------------------------------------------------
	// Watchdog: too long with nothing moving on either side
	// ------------------------------------------------------------------------
	always @(posedge clk) begin : watchdog
		int idle;
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
			idle = 0;
		end else begin
			idle++;
			if (idle >= IDLE_LIMIT) begin
				$display("FAILURE");
				$finish;
			end
		end
	end

	// ------------------------------------------------------------------------
	// Sender: bursts of random length; a zero gap keeps valid high throughout
	// ------------------------------------------------------------------------
	initial begin : tx
		int burst;
		int gap;
		foreach (directed_rows[i]) begin
			stim_q.insert(stim_q.size(), directed_rows[i]);
		end
		build_random();
		burst = 0;
		@(posedge arst_n);
		@(posedge clk);
		for (int i = 0; i < stim_q.size(); i++) begin
			if (burst == 0) begin
				gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
				if (gap > 0) begin
					s_tvalid <= 1'b0;
					repeat (gap) @(posedge clk);
				end
				burst = $urandom_range(1, 24);
			end
			s_tvalid <= 1'b1;
			s_tdata  <= stim_q[i].data;
			do @(posedge clk); while (!s_tready);
			burst--;
		end
		s_tvalid <= 1'b0;

		// drain, then keep watching for any stray output
		@(posedge clk);
		while (pending_bytes.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		if (pending_bytes.size() != 0) begin
			$error("%0d predicted output items never arrived", pending_bytes.size());
			n_err++;
		end
		if (n_err == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

endmodule
